// ===== rtl/fmpd_pkg.sv =====
// ---------------------------------------------------------------------------
// fmpd_pkg
// Shared types, register map and lookup helpers of the FM phase demodulator.
// ---------------------------------------------------------------------------
package fmpd_pkg;

    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int PHASE_W = 5;
    localparam int CODE_W  = 6;
    localparam int LEVEL_W = 3;

    localparam logic [5:0] PEDESTAL_RST  = 6'd20;
    localparam logic [2:0] GAIN_RST      = 3'd2;
    localparam logic [7:0] FLOOR_RST     = 8'd16;
    localparam logic [5:0] MILD_RST      = 6'd8;
    localparam logic [5:0] MEDIUM_RST    = 6'd28;
    localparam logic [5:0] MAXCORR_RST   = 6'd24;
    localparam logic [2:0] START_LVL_RST = 3'd2;

    typedef enum logic [2:0] {
        REG_PEDESTAL       = 3'd0,
        REG_GAIN_STEP      = 3'd1,
        REG_POWER_FLOOR    = 3'd2,
        REG_MILD_LIMIT     = 3'd3,
        REG_MEDIUM_LIMIT   = 3'd4,
        REG_MAX_CORRECTION = 3'd5,
        REG_START_LEVEL    = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [5:0] pedestal;
        logic [2:0] gain_step;
        logic [7:0] power_floor;
        logic [5:0] mild_limit;
        logic [5:0] medium_limit;
        logic [5:0] max_correction;
        logic [2:0] start_level;
    } t_cfg;

    typedef struct packed {
        logic load_s2;
        logic adv_s2;
        logic load_s3;
        logic adv_s3;
    } t_pipe_ctl;

    typedef logic [255:0][PHASE_W-1:0] t_phase_lut;

    localparam int COS_BASE [9] = '{
        65536, 64277, 60547, 54491, 46341, 36410, 25080, 12785, 0
    };

    function automatic int f_cos_dir(input int k_in);
        int k;
        k = k_in % 32;
        if (k > 16) begin
            k = 32 - k;
        end
        if (k > 8) begin
            return -COS_BASE[16 - k];
        end
        return COS_BASE[k];
    endfunction

    function automatic int f_nibble(input int v);
        int n;
        n = v % 16;
        if (n >= 8) begin
            n = n - 16;
        end
        return n;
    endfunction

    function automatic t_phase_lut f_build_phase_lut();
        t_phase_lut lut;
        int x;
        int y;
        int best;
        int best_dot;
        int dot;
        for (int b = 0; b < 256; b++) begin
            x = 2 * f_nibble(b / 16) + 1;
            y = 2 * f_nibble(b) + 1;
            best = 0;
            best_dot = x * f_cos_dir(0) + y * f_cos_dir(24);
            for (int k = 1; k < 32; k++) begin
                dot = x * f_cos_dir(k) + y * f_cos_dir(k + 24);
                if (dot > best_dot) begin
                    best_dot = dot;
                    best = k;
                end
            end
            lut[b] = PHASE_W'(best);
        end
        return lut;
    endfunction

    localparam t_phase_lut PHASE_LUT = f_build_phase_lut();

    function automatic logic f_byte_conf(input logic [7:0] b, input logic [7:0] floor_v);
        logic signed [7:0] i8;
        logic signed [7:0] q8;
        logic [7:0]        pw;
        logic              i_rail;
        logic              q_rail;
        i8 = {{4{b[7]}}, b[7:4]};
        q8 = {{4{b[3]}}, b[3:0]};
        pw = 8'(i8 * i8 + q8 * q8);
        i_rail = (b[7:4] == 4'h8) || (b[7:4] == 4'h7);
        q_rail = (b[3:0] == 4'h8) || (b[3:0] == 4'h7);
        return (pw >= floor_v) && !(i_rail && q_rail);
    endfunction

endpackage

// ===== rtl/fmpd_apb_regs.sv =====
// ---------------------------------------------------------------------------
// fmpd_apb_regs
// APB register file holding the demodulator configuration.
// ---------------------------------------------------------------------------
module fmpd_apb_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [fmpd_pkg::ADDR_W-1:0] paddr,
    input  logic [fmpd_pkg::DATA_W-1:0] pwdata,
    output logic [fmpd_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    output fmpd_pkg::t_cfg            o_cfg
);
    import fmpd_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pedestal       <= PEDESTAL_RST;
            r_cfg.gain_step      <= GAIN_RST;
            r_cfg.power_floor    <= FLOOR_RST;
            r_cfg.mild_limit     <= MILD_RST;
            r_cfg.medium_limit   <= MEDIUM_RST;
            r_cfg.max_correction <= MAXCORR_RST;
            r_cfg.start_level    <= START_LVL_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_PEDESTAL:       r_cfg.pedestal       <= pwdata[5:0];
                REG_GAIN_STEP:      r_cfg.gain_step      <= pwdata[2:0];
                REG_POWER_FLOOR:    r_cfg.power_floor    <= pwdata[7:0];
                REG_MILD_LIMIT:     r_cfg.mild_limit     <= pwdata[5:0];
                REG_MEDIUM_LIMIT:   r_cfg.medium_limit   <= pwdata[5:0];
                REG_MAX_CORRECTION: r_cfg.max_correction <= pwdata[5:0];
                REG_START_LEVEL:    r_cfg.start_level    <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_PEDESTAL:       prdata = DATA_W'(r_cfg.pedestal);
            REG_GAIN_STEP:      prdata = DATA_W'(r_cfg.gain_step);
            REG_POWER_FLOOR:    prdata = DATA_W'(r_cfg.power_floor);
            REG_MILD_LIMIT:     prdata = DATA_W'(r_cfg.mild_limit);
            REG_MEDIUM_LIMIT:   prdata = DATA_W'(r_cfg.medium_limit);
            REG_MAX_CORRECTION: prdata = DATA_W'(r_cfg.max_correction);
            REG_START_LEVEL:    prdata = DATA_W'(r_cfg.start_level);
            default:            prdata = '0;
        endcase
    end

endmodule

// ===== rtl/fmpd_lane.sv =====
// ---------------------------------------------------------------------------
// fmpd_lane
// One sample lane: table phase lookup and confidence test of one I/Q byte.
// ---------------------------------------------------------------------------
module fmpd_lane (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [7:0]                   i_sample,
    input  logic [7:0]                   i_power_floor,
    output logic [fmpd_pkg::PHASE_W-1:0] o_phase,
    output logic                         o_conf
);
    import fmpd_pkg::*;

    logic [PHASE_W-1:0] r_phase;
    logic               r_conf;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_phase <= PHASE_LUT[i_sample];
            r_conf  <= f_byte_conf(i_sample, i_power_floor);
        end
    end

    assign o_phase = r_phase;
    assign o_conf  = r_conf;

endmodule

// ===== rtl/fmpd_merge.sv =====
// ---------------------------------------------------------------------------
// fmpd_merge
// Merges the two lanes: phase steps, scaled observation, level tracker
// and output code register.
// ---------------------------------------------------------------------------
module fmpd_merge (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fmpd_pkg::t_pipe_ctl          i_ctl,
    input  fmpd_pkg::t_cfg               i_cfg,
    input  logic [fmpd_pkg::PHASE_W-1:0] i_phase0,
    input  logic [fmpd_pkg::PHASE_W-1:0] i_phase1,
    input  logic                         i_conf0,
    input  logic                         i_conf1,
    output logic [fmpd_pkg::CODE_W-1:0]  o_code
);
    import fmpd_pkg::*;

    // stage 2: steps and observation
    logic [PHASE_W-1:0]  r_last_phase;
    logic [PHASE_W-1:0]  w_b0;
    logic [PHASE_W-1:0]  w_b1;
    logic [5:0]          w_biased;
    logic signed [11:0]  w_steps;
    logic signed [11:0]  w_gain;
    logic signed [11:0]  w_obs_raw;
    logic [CODE_W-1:0]   w_obs;
    logic [3:0]          w_par_conf;

    logic [CODE_W-1:0]   r_obs;
    logic                r_conf;
    logic [3:0]          r_par_conf;

    // stage 3: tracker
    logic [LEVEL_W-1:0]  r_level;
    logic [CODE_W-1:0]   r_code;
    logic [CODE_W-1:0]   w_pred;
    logic signed [7:0]   w_innov;
    logic                w_neg;
    logic [5:0]          w_mag;
    logic [5:0]          w_half;
    logic [5:0]          w_smag;
    logic signed [7:0]   w_code_raw;
    logic [CODE_W-1:0]   n_code;

    always_comb begin
        w_b0      = i_phase0 - r_last_phase + PHASE_W'(16);
        w_b1      = i_phase1 - i_phase0 + PHASE_W'(16);
        w_biased  = 6'(w_b0) + 6'(w_b1);
        w_steps   = $signed({6'b0, w_biased}) - 12'sd32;
        w_gain    = $signed({8'b0, 1'b0, i_cfg.gain_step}) + 12'sd1;
        w_obs_raw = $signed({6'b0, i_cfg.pedestal}) + 12'((w_steps * w_gain) <<< 1);
        if (w_obs_raw < 0) begin
            w_obs = '0;
        end else if (w_obs_raw > 12'sd63) begin
            w_obs = 6'd63;
        end else begin
            w_obs = w_obs_raw[5:0];
        end
        for (int l = 0; l < 4; l++) begin
            w_par_conf[l] = f_byte_conf({2'(l), w_biased}, i_cfg.power_floor);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_phase <= '0;
        end else if (i_ctl.adv_s2) begin
            r_last_phase <= i_phase1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_s2) begin
            r_obs      <= w_obs;
            r_conf     <= i_conf0 && i_conf1;
            r_par_conf <= w_par_conf;
        end
    end

    always_comb begin
        w_pred  = {r_level, 3'b100};
        w_innov = $signed({2'b0, r_obs}) - $signed({2'b0, w_pred});
        w_neg   = w_innov[7];
        w_mag   = w_neg ? 6'(-w_innov) : w_innov[5:0];
        w_half  = 6'((7'(w_mag) + 7'd1) >> 1);
        if (w_mag <= i_cfg.mild_limit) begin
            w_smag = w_mag;
        end else if (w_mag <= i_cfg.medium_limit) begin
            w_smag = w_half;
        end else if (w_mag > i_cfg.max_correction) begin
            w_smag = i_cfg.max_correction;
        end else begin
            w_smag = w_mag;
        end
        w_code_raw = w_neg ? $signed({2'b0, w_pred}) - $signed({2'b0, w_smag})
                           : $signed({2'b0, w_pred}) + $signed({2'b0, w_smag});
        if (r_conf) begin
            n_code = r_obs;
        end else begin
            if (w_code_raw < 0) begin
                n_code = '0;
            end else if (w_code_raw > 8'sd63) begin
                n_code = 6'd63;
            end else begin
                n_code = w_code_raw[5:0];
            end
            if (!r_level[2]) begin
                n_code[0] = r_par_conf[r_level[1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= START_LVL_RST;
        end else if (i_ctl.adv_s3) begin
            r_level <= n_code[5:3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_s3) begin
            r_code <= n_code;
        end
    end

    assign o_code = r_code;

endmodule

// ===== rtl/iq_fm_phase_demodulator_core.sv =====
// ---------------------------------------------------------------------------
// iq_fm_phase_demodulator_core
// FM phase-difference demodulator: two byte lanes, merge and tracker stage.
// ---------------------------------------------------------------------------
//  channel | handshake                  | payload
//  in      | i_in_valid / o_in_stall    | i_first_sample, i_second_sample
//  out     | o_out_valid / i_out_stall  | o_dac_code
//  cfg     | psel penable pwrite pready | paddr, pwdata, prdata
//
//  One item per cycle sustained while i_out_stall is low; three register
//  stages (valids r_v1, r_v2, r_v3); o_out_valid is the r_v3 flag.
//  The tracker level loop closes in stage 3; one item per unstalled cycle.
//  Reset clears all valids, the last phase and sets the tracker level to 2.
//  A stalled output holds the whole pipeline; empty stages still fill.
// ---------------------------------------------------------------------------
module iq_fm_phase_demodulator_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [7:0]                  i_first_sample,
    input  logic [7:0]                  i_second_sample,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [5:0]                  o_dac_code,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fmpd_pkg::ADDR_W-1:0] paddr,
    input  logic [fmpd_pkg::DATA_W-1:0] pwdata,
    output logic [fmpd_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import fmpd_pkg::*;

    t_cfg               w_cfg;
    t_pipe_ctl          w_ctl;
    logic               r_v1;
    logic               r_v2;
    logic               r_v3;
    logic               w_rdy1;
    logic               w_rdy2;
    logic               w_rdy3;
    logic [PHASE_W-1:0] w_phase0;
    logic [PHASE_W-1:0] w_phase1;
    logic               w_conf0;
    logic               w_conf1;

    assign w_rdy3 = !r_v3 || !i_out_stall;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;

    assign w_ctl.load_s2 = w_rdy2;
    assign w_ctl.adv_s2  = w_rdy2 && r_v1;
    assign w_ctl.load_s3 = w_rdy3;
    assign w_ctl.adv_s3  = w_rdy3 && r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_in_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    fmpd_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    fmpd_lane u_lane0 (
        .i_clk         (i_clk),
        .i_en          (w_rdy1),
        .i_sample      (i_first_sample),
        .i_power_floor (w_cfg.power_floor),
        .o_phase       (w_phase0),
        .o_conf        (w_conf0)
    );

    fmpd_lane u_lane1 (
        .i_clk         (i_clk),
        .i_en          (w_rdy1),
        .i_sample      (i_second_sample),
        .i_power_floor (w_cfg.power_floor),
        .o_phase       (w_phase1),
        .o_conf        (w_conf1)
    );

    fmpd_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_cfg    (w_cfg),
        .i_phase0 (w_phase0),
        .i_phase1 (w_phase1),
        .i_conf0  (w_conf0),
        .i_conf1  (w_conf1),
        .o_code   (o_dac_code)
    );

    assign o_in_stall  = !w_rdy1;
    assign o_out_valid = r_v3;

endmodule
